@@ src/sgmpca_pkg.sv @@
package sgmpca_pkg;

   localparam int COST_W = 4;
   localparam int SUM_W = 10;
   localparam int PATH_W = 8;
   localparam int DISP_IDX_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PATH_W-1:0] SMALL_STEP_RESET = 8'd10;
   localparam logic [PATH_W-1:0] LARGE_STEP_RESET = 8'd120;
   localparam logic [PATH_W-1:0] PATH_MAX = 8'hFF;
   localparam logic [SUM_W-1:0] SUM_MAX = 10'h3FF;

   // Register select is byte address bit 2.
   localparam logic REG_SMALL_STEP = 1'b0;
   localparam logic REG_LARGE_STEP = 1'b1;

   typedef struct packed {
      logic [PATH_W-1:0] small_step_penalty;
      logic [PATH_W-1:0] large_step_penalty;
   } penalty_cfg_type;

   typedef struct packed {
      logic first_disp;
      logic last_disp;
      logic edge_pixel;
   } path_ctrl_type;

endpackage

@@ src/sgmpca_csr.sv @@
module sgmpca_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sgmpca_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sgmpca_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sgmpca_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output sgmpca_pkg::penalty_cfg_type          cfg
);
   import sgmpca_pkg::*;

   penalty_cfg_type cfg_ff;
   penalty_cfg_type cfg_in;
   logic            wr_en;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_SMALL_STEP: cfg_in.small_step_penalty = csr_pwdata[PATH_W-1:0];
            REG_LARGE_STEP: cfg_in.large_step_penalty = csr_pwdata[PATH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SMALL_STEP: csr_prdata = {{(CSR_DATA_W-PATH_W){1'b0}}, cfg_ff.small_step_penalty};
         REG_LARGE_STEP: csr_prdata = {{(CSR_DATA_W-PATH_W){1'b0}}, cfg_ff.large_step_penalty};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_step_penalty <= SMALL_STEP_RESET;
         cfg_ff.large_step_penalty <= LARGE_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/sgmpca_prev_line.sv @@
module sgmpca_prev_line #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [sgmpca_pkg::PATH_W-1:0]     path_in,
   output logic [sgmpca_pkg::PATH_W-1:0]     here_out,
   output logic [sgmpca_pkg::PATH_W-1:0]     up_out
);
   import sgmpca_pkg::*;

   // The previous pixel's path vector rotates past the head: entry 0 holds the
   // cost at the current disparity, entry 1 the one just above it. New costs
   // enter at the tail, so after a full pixel the line again starts at zero.
   logic [PATH_W-1:0] line_ff [DEPTH];

   assign here_out = line_ff[0];
   assign up_out = line_ff[1];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            line_ff[i] <= line_ff[i+1];
         end
         line_ff[DEPTH-1] <= path_in;
      end
   end

endmodule

@@ src/sgmpca_path_calc.sv @@
module sgmpca_path_calc (
   input  sgmpca_pkg::penalty_cfg_type          cfg,
   input  sgmpca_pkg::path_ctrl_type            ctrl,
   input  logic [sgmpca_pkg::PATH_W-1:0]        old_here,
   input  logic [sgmpca_pkg::PATH_W-1:0]        old_up,
   input  logic [sgmpca_pkg::PATH_W-1:0]        held_low,
   input  logic [sgmpca_pkg::PATH_W-1:0]        prev_min,
   input  logic [sgmpca_pkg::COST_W-1:0]        step_cost,
   input  logic [sgmpca_pkg::SUM_W-1:0]         sum_in,
   input  logic                                 start_sum,
   output logic [sgmpca_pkg::PATH_W-1:0]        path_cost,
   output logic [sgmpca_pkg::SUM_W-1:0]         sum_out
);
   import sgmpca_pkg::*;

   logic [PATH_W:0]   low_cand;
   logic [PATH_W:0]   up_cand;
   logic [PATH_W:0]   jump_cand;
   logic [PATH_W:0]   best;
   logic [PATH_W+1:0] total;
   logic [PATH_W+1:0] prev_ext;
   logic [PATH_W+1:0] diff;
   logic [SUM_W:0]    sum_wide;

   assign low_cand = {1'b0, held_low} + {1'b0, cfg.small_step_penalty};
   assign up_cand = {1'b0, old_up} + {1'b0, cfg.small_step_penalty};
   assign jump_cand = {1'b0, prev_min} + {1'b0, cfg.large_step_penalty};
   assign prev_ext = {2'b0, prev_min};

   always_comb begin
      best = {1'b0, old_here};
      if (!ctrl.first_disp && low_cand < best) begin
         best = low_cand;
      end
      if (!ctrl.last_disp && up_cand < best) begin
         best = up_cand;
      end
      if (jump_cand < best) begin
         best = jump_cand;
      end
      total = {1'b0, best} + {{(PATH_W+2-COST_W){1'b0}}, step_cost};
      diff = (total < prev_ext) ? '0 : total - prev_ext;

      if (ctrl.edge_pixel) begin
         path_cost = {{(PATH_W-COST_W){1'b0}}, step_cost};
      end else if (diff > {2'b0, PATH_MAX}) begin
         path_cost = PATH_MAX;
      end else begin
         path_cost = diff[PATH_W-1:0];
      end

      if (start_sum) begin
         sum_wide = {{(SUM_W+1-PATH_W){1'b0}}, path_cost};
      end else begin
         sum_wide = {1'b0, sum_in} + {{(SUM_W+1-PATH_W){1'b0}}, path_cost};
      end
      sum_out = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
   end

endmodule

@@ src/sgm_path_cost_aggregation_core.sv @@
// Semi-global matching path cost aggregation along one scan path. Items are the
// matching costs of one pixel, disparity 0 to DISPARITIES-1 in order, pixels in
// scan order, and every item gives one result: the path cost for that disparity
// plus the running sum. The core takes one item per clock unless rsp_ready
// holds results back, and each result passes the input register, then the
// result register; the rate is set by the single pass from the input register
// through the cost recurrence and four-way minimum into the result register. The
// previous pixel's path vector sits in a shift line of DISPARITIES entries that
// rotates once per item and needs no clearing after reset, so the first item
// after reset must start a line. Penalties P1 and P2 are at byte addresses 0
// and 4 and should be changed only while the core is idle.
module sgm_path_cost_aggregation_core #(
   parameter int DISPARITIES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sgmpca_pkg::COST_W-1:0]          req_step_cost,
   input  logic [sgmpca_pkg::SUM_W-1:0]           req_sum_in,
   input  logic                                   req_line_start,
   input  logic                                   req_start_sum,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sgmpca_pkg::PATH_W-1:0]          rsp_path_cost,
   output logic [sgmpca_pkg::SUM_W-1:0]           rsp_sum_out,
   output logic [sgmpca_pkg::DISP_IDX_W-1:0]      rsp_disparity_index,
   output logic                                   rsp_pixel_done,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [sgmpca_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sgmpca_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sgmpca_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import sgmpca_pkg::*;

   localparam int CNT_W = $clog2(DISPARITIES);
   localparam logic [CNT_W-1:0] LAST_DISP = CNT_W'(DISPARITIES - 1);

   penalty_cfg_type cfg;
   path_ctrl_type   ctrl;

   // Input register.
   logic              s1_valid_ff, s1_valid_in;
   logic [COST_W-1:0] s1_cost_ff;
   logic [SUM_W-1:0]  s1_sum_ff;
   logic              s1_line_ff;
   logic              s1_start_ff;

   // Recurrence state.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              edge_ff, edge_in;
   logic [PATH_W-1:0] held_ff, held_in;
   logic [PATH_W-1:0] prev_min_ff, prev_min_in;
   logic [PATH_W-1:0] run_min_ff, run_min_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PATH_W-1:0]     path_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [DISP_IDX_W-1:0] disp_ff;
   logic                  done_ff;

   logic                  rsp_load;
   logic                  s1_move;
   logic                  req_take;
   logic [PATH_W-1:0]     old_here;
   logic [PATH_W-1:0]     old_up;
   logic [PATH_W-1:0]     path_cost;
   logic [SUM_W-1:0]      sum_out;
   logic [PATH_W-1:0]     run_min_upd;
   logic [CNT_W+DISP_IDX_W-1:0] disp_ext;

   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && rsp_load;
   assign req_ready = !s1_valid_ff || rsp_load;
   assign req_take = req_valid && req_ready;

   assign ctrl.first_disp = (cnt_ff == '0);
   assign ctrl.last_disp = (cnt_ff == LAST_DISP);
   // Line start is sampled at disparity 0 and holds for the rest of the pixel.
   assign ctrl.edge_pixel = ctrl.first_disp ? s1_line_ff : edge_ff;

   assign disp_ext = {{DISP_IDX_W{1'b0}}, cnt_ff};
   assign run_min_upd = (path_cost < run_min_ff) ? path_cost : run_min_ff;

   sgmpca_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sgmpca_prev_line #(
      .DEPTH (DISPARITIES)
   ) u_prev_line (
      .clock    (clock),
      .shift_en (s1_move),
      .path_in  (path_cost),
      .here_out (old_here),
      .up_out   (old_up)
   );

   sgmpca_path_calc u_path_calc (
      .cfg       (cfg),
      .ctrl      (ctrl),
      .old_here  (old_here),
      .old_up    (old_up),
      .held_low  (held_ff),
      .prev_min  (prev_min_ff),
      .step_cost (s1_cost_ff),
      .sum_in    (s1_sum_ff),
      .start_sum (s1_start_ff),
      .path_cost (path_cost),
      .sum_out   (sum_out)
   );

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
      cnt_in = cnt_ff;
      edge_in = edge_ff;
      held_in = held_ff;
      prev_min_in = prev_min_ff;
      run_min_in = run_min_ff;
      if (s1_move) begin
         edge_in = ctrl.edge_pixel;
         held_in = old_here;
         if (ctrl.last_disp) begin
            cnt_in = '0;
            prev_min_in = run_min_upd;
            run_min_in = PATH_MAX;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            run_min_in = run_min_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         edge_ff <= 1'b0;
         held_ff <= '0;
         prev_min_ff <= PATH_MAX;
         run_min_ff <= PATH_MAX;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         edge_ff <= edge_in;
         held_ff <= held_in;
         prev_min_ff <= prev_min_in;
         run_min_ff <= run_min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cost_ff <= req_step_cost;
         s1_sum_ff <= req_sum_in;
         s1_line_ff <= req_line_start;
         s1_start_ff <= req_start_sum;
      end
      if (s1_move) begin
         path_ff <= path_cost;
         sum_ff <= sum_out;
         disp_ff <= disp_ext[DISP_IDX_W-1:0];
         done_ff <= ctrl.last_disp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_path_cost = path_ff;
   assign rsp_sum_out = sum_ff;
   assign rsp_disparity_index = disp_ff;
   assign rsp_pixel_done = done_ff;

`ifndef SYNTHESIS
   a_done_on_last_disp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_done |-> rsp_disparity_index == DISP_IDX_W'(DISPARITIES - 1))
      else $error("pixel_done on a disparity other than the last");

   a_sum_covers_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sum_out >= {{(SUM_W-PATH_W){1'b0}}, rsp_path_cost})
      else $error("sum_out below path_cost");

   a_run_min_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_move && ctrl.last_disp |=> run_min_ff == PATH_MAX)
      else $error("running minimum not restarted after the last disparity");

   a_counter_steps: assert property (@(posedge clock) disable iff (reset)
      s1_move && !ctrl.last_disp |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("disparity counter did not advance with the item");
`endif

endmodule

@@ test/sgm_path_cost_aggregation_core_check.sv @@
module sgm_path_cost_aggregation_core_check #(
   parameter int DISPARITIES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [sgmpca_pkg::COST_W-1:0]          req_step_cost,
   input  logic [sgmpca_pkg::SUM_W-1:0]           req_sum_in,
   input  logic                                   req_line_start,
   input  logic                                   req_start_sum,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [sgmpca_pkg::PATH_W-1:0]          rsp_path_cost,
   input  logic [sgmpca_pkg::SUM_W-1:0]           rsp_sum_out,
   input  logic [sgmpca_pkg::DISP_IDX_W-1:0]      rsp_disparity_index,
   input  logic                                   rsp_pixel_done,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [sgmpca_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sgmpca_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic                                   csr_pready,
   output int                                     failures,
   output int                                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import sgmpca_pkg::*;

   typedef struct packed {
      logic [PATH_W-1:0]     path_cost;
      logic [SUM_W-1:0]      sum_out;
      logic [DISP_IDX_W-1:0] disparity_index;
      logic                  pixel_done;
   } path_result_type;

   path_result_type expected_paths[$];

   logic [PATH_W-1:0] small_step;
   logic [PATH_W-1:0] large_step;
   logic [PATH_W-1:0] prior_path [DISPARITIES];
   logic [PATH_W-1:0] prior_min;
   logic [PATH_W-1:0] run_min;
   logic [PATH_W-1:0] held_lower;
   int unsigned       disp_count;
   logic              edge_px;

   initial begin
      failures = 0;
      outstanding = 0;
   end

   // Advances the path recurrence by one disparity and returns the result it gives.
   function automatic path_result_type aggregate_path_cost(
      input logic [COST_W-1:0] step_cost,
      input logic [SUM_W-1:0]  sum_in,
      input logic              line_start,
      input logic              start_sum
   );
      path_result_type result;
      int unsigned disp;
      int unsigned here;
      int unsigned p1;
      int unsigned base;
      int unsigned best;
      int unsigned path;
      int unsigned sum;
      logic last;
      disp = disp_count;
      if (disp >= DISPARITIES) begin
         disp = 0;
      end
      if (disp == 0) begin
         edge_px = line_start;
      end
      last = (disp == DISPARITIES - 1);
      here = prior_path[disp];
      p1 = small_step;
      base = prior_min;
      if (edge_px) begin
         path = step_cost;
      end else begin
         best = here;
         if (disp > 0 && int'(held_lower) + p1 < best) begin
            best = int'(held_lower) + p1;
         end
         if (!last && int'(prior_path[disp + 1]) + p1 < best) begin
            best = int'(prior_path[disp + 1]) + p1;
         end
         if (base + large_step < best) begin
            best = base + large_step;
         end
         best = best + step_cost;
         path = (best < base) ? 0 : best - base;
         if (path > PATH_MAX) begin
            path = PATH_MAX;
         end
      end
      held_lower = PATH_W'(here);
      prior_path[disp] = PATH_W'(path);
      if (path < run_min) begin
         run_min = PATH_W'(path);
      end
      sum = start_sum ? path : sum_in + path;
      if (sum > SUM_MAX) begin
         sum = SUM_MAX;
      end
      result.path_cost = PATH_W'(path);
      result.sum_out = SUM_W'(sum);
      result.disparity_index = DISP_IDX_W'(disp);
      result.pixel_done = last;
      if (last) begin
         prior_min = run_min;
         run_min = PATH_MAX;
         disp_count = 0;
      end else begin
         disp_count = disp + 1;
      end
      return result;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      path_result_type want;
      path_result_type got;
      if (reset) begin
         small_step = SMALL_STEP_RESET;
         large_step = LARGE_STEP_RESET;
         foreach (prior_path[i]) begin
            prior_path[i] = '0;
         end
         prior_min = PATH_MAX;
         run_min = PATH_MAX;
         held_lower = '0;
         disp_count = 0;
         edge_px = 1'b0;
         expected_paths.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_SMALL_STEP) begin
               small_step = csr_pwdata[PATH_W-1:0];
            end else begin
               large_step = csr_pwdata[PATH_W-1:0];
            end
         end
         // Results leave before new items enter, so an item never meets its own result.
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_path_cost, rsp_sum_out, rsp_disparity_index, rsp_pixel_done};
            if (expected_paths.size() == 0) begin
               note_failure($sformatf("unexpected result: path %0d sum %0d index %0d done %0b",
                  got.path_cost, got.sum_out, got.disparity_index, got.pixel_done));
            end else begin
               want = expected_paths.pop_front();
               if (got !== want) begin
                  note_failure($sformatf({"result mismatch: expected path %0d sum %0d index %0d ",
                     "done %0b, got path %0d sum %0d index %0d done %0b"},
                     want.path_cost, want.sum_out, want.disparity_index, want.pixel_done,
                     got.path_cost, got.sum_out, got.disparity_index, got.pixel_done));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_paths.push_back(aggregate_path_cost(req_step_cost, req_sum_in,
               req_line_start, req_start_sum));
         end
      end
      outstanding = expected_paths.size();
   end

endmodule

@@ test/sgm_path_cost_aggregation_core_test.sv @@
module sgm_path_cost_aggregation_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sgmpca_pkg::*;

   localparam int DISPARITIES = 64;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_OFF_AT = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef enum {PIXEL_MIXED, PIXEL_CLIMB} pixel_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COST_W-1:0]     req_step_cost = '0;
   logic [SUM_W-1:0]      req_sum_in = '0;
   logic                  req_line_start = 1'b0;
   logic                  req_start_sum = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PATH_W-1:0]     rsp_path_cost;
   logic [SUM_W-1:0]      rsp_sum_out;
   logic [DISP_IDX_W-1:0] rsp_disparity_index;
   logic                  rsp_pixel_done;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int idle_cycles = 0;
   bit sender_quiet = 1'b0;

   sgm_path_cost_aggregation_core #(
      .DISPARITIES(DISPARITIES)
   ) uut (.*);

   sgm_path_cost_aggregation_core_check #(
      .DISPARITIES(DISPARITIES)
   ) path_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_step_cost(req_step_cost),
      .req_sum_in(req_sum_in), .req_line_start(req_line_start), .req_start_sum(req_start_sum),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_path_cost(rsp_path_cost),
      .rsp_sum_out(rsp_sum_out), .rsp_disparity_index(rsp_disparity_index),
      .rsp_pixel_done(rsp_pixel_done),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .failures(failures), .outstanding(outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [COST_W-1:0] draw_step_cost();
      // Costs above the Hamming range show up now and then.
      if ($urandom_range(0, 15) == 0) begin
         return COST_W'($urandom_range(9, 15));
      end
      return COST_W'($urandom_range(0, 8));
   endfunction

   function automatic logic [SUM_W-1:0] draw_sum_in();
      if ($urandom_range(0, 3) == 0) begin
         return SUM_W'($urandom_range(900, 1023));
      end
      return SUM_W'($urandom);
   endfunction

   task automatic send_cost(
      input logic [COST_W-1:0] step_cost,
      input logic [SUM_W-1:0]  sum_in,
      input logic              line_start,
      input logic              start_sum
   );
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_step_cost <= step_cost;
      req_sum_in <= sum_in;
      req_line_start <= line_start;
      req_start_sum <= start_sum;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // Line start only counts at disparity 0; later items carry a random bit that must be ignored.
   task automatic send_pixel(input logic starts_line, input pixel_kind_type kind);
      logic [COST_W-1:0] step_cost;
      sender_quiet = ($urandom_range(0, 3) == 0);
      for (int d = 0; d < DISPARITIES; d++) begin
         if (kind == PIXEL_CLIMB) begin
            step_cost = (d == 0) ? '0 : COST_W'($urandom_range(13, 15));
         end else begin
            step_cost = draw_step_cost();
         end
         send_cost(step_cost, draw_sum_in(), (d == 0) ? starts_line : 1'($urandom),
            1'($urandom));
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_penalty(input logic reg_sel, input logic [PATH_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(
      input logic [PATH_W-1:0] small_step,
      input logic [PATH_W-1:0] large_step,
      input int                pixels,
      input pixel_kind_type    kind
   );
      wait_until_drained();
      write_penalty(REG_SMALL_STEP, small_step);
      write_penalty(REG_LARGE_STEP, large_step);
      for (int p = 0; p < pixels; p++) begin
         if (kind == PIXEL_CLIMB) begin
            send_pixel(p == 0, kind);
         end else begin
            send_pixel($urandom_range(0, 3) == 0, kind);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // The first pixel starts a line, so every stored path entry is written before use.
      for (int d = 0; d < DISPARITIES; d++) begin
         if (d < 24) begin
            send_cost(COST_W'(d % 16),
               (d % 3 == 0) ? SUM_W'(0) : (d % 3 == 1) ? SUM_MAX : SUM_W'(d * 37),
               (d == 0) || (d % 5 == 2), d % 4 == 3);
         end else begin
            send_cost(draw_step_cost(), draw_sum_in(), 1'($urandom), 1'($urandom));
         end
      end
      run_phase(8'd0, 8'd0, 1, PIXEL_MIXED);
      run_phase(8'd255, 8'd247, 1, PIXEL_MIXED);
      run_phase(8'd1, 8'd255, 1, PIXEL_MIXED);
      run_phase(PATH_W'($urandom), PATH_W'($urandom_range(0, 247)), 1, PIXEL_MIXED);
      run_phase(8'd0, 8'd247, 1, PIXEL_MIXED);
      // With both penalties at their top, disparity 0 pins the minimum at zero while every
      // other entry grows by its cost from one pixel to the next.
      run_phase(8'd255, 8'd255, 2, PIXEL_CLIMB);
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (failures == 0) begin
         $display("sgm_path_cost_aggregation_core_test OK");
      end else begin
         $display("sgm_path_cost_aggregation_core_test NOT OK");
      end
      $finish;
   end

   initial begin
      int pause;
      int results_taken;
      bit receiver_quiet;
      results_taken = 0;
      receiver_quiet = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (results_taken % 64 == 0) begin
            receiver_quiet = ($urandom_range(0, 2) == 0);
         end
         pause = receiver_quiet ? 0 : $urandom_range(0, 11);
         // One long stall lets the pipeline fill and push back on the item input.
         if (results_taken == HOLD_OFF_AT) begin
            pause = HOLD_OFF_CYCLES;
         end
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
         results_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("sgm_path_cost_aggregation_core_test NOT OK");
            $finish;
         end
      end
   end

endmodule
